// File: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the triangle contour slicer
// Holds the payload structs, the register indexes and the state encoding.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int unsigned CW = 24;
    localparam int unsigned SW = 23;
    localparam int unsigned IW = 8;
    localparam int unsigned FW = 16;

    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] corner_a_x;
        logic signed [CW-1:0] corner_a_y;
        logic signed [CW-1:0] corner_a_z;
        logic signed [CW-1:0] corner_b_x;
        logic signed [CW-1:0] corner_b_y;
        logic signed [CW-1:0] corner_b_z;
        logic signed [CW-1:0] corner_c_x;
        logic signed [CW-1:0] corner_c_y;
        logic signed [CW-1:0] corner_c_z;
    } t_tri;

    typedef struct packed {
        logic                 found;
        logic        [IW-1:0] level_index;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_seg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

// File: rtl/triangle_contour_slicer_core.sv
// ----------------------------------------------------------------------------
// triangle_contour_slicer_core: first contour level that cuts two triangle edges
// Scans levels from the top, then interpolates both crossing points with a
// bit-serial divider and a bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | tcs_pkg::t_tri
//  out     | output    | o_valid / i_stall  | tcs_pkg::t_seg
//  cfg     | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Per transaction the core loads the triangle, scans the levels and, when a
// level is found, runs two divisions and six multiplies before the output
// state; when no level is found it goes from the scan straight to the output
// state. One level is tested per cycle; the shared one-bit-a-cycle divider
// and multiplier handle the interpolation. The result is registered into the
// output register as the core leaves its output state.
// Reset (synchronous, active low) returns to idle with default registers.
// A finished result moves into the output register, which holds while
// i_stall is high; the core holds its own result while the output register
// is still full, and stalls the input whenever it is not idle.
module triangle_contour_slicer_core #(
    parameter int MAX_LEVELS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tcs_pkg::t_tri   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output tcs_pkg::t_seg   o_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [23:0]     i_cfg_data
);
    import tcs_pkg::*;

    localparam int KW = $clog2(MAX_LEVELS + 1);
    localparam int HW = CW + 2;

    t_state r_state, n_state;

    logic signed [CW-1:0] r_top, r_bot;
    logic        [SW-1:0] r_step;

    // Vertex store: index 0 = a, 1 = b, 2 = c; coordinate 0..2 = x, y, z.
    logic signed [CW-1:0] r_v [3][3];
    logic signed [HW-1:0] r_h;
    logic        [KW-1:0] r_k;
    logic                 r_found;

    // Chosen edges: lower and higher endpoint vertex index per crossing.
    logic [1:0] r_lo [2];
    logic [1:0] r_hi [2];

    // Serial unit state.
    logic        [2:0]    r_sel;     // which coordinate (0..5) is in the multiplier
    logic        [4:0]    r_cnt;
    logic        [CW:0]   r_rem;
    logic        [CW:0]   r_den;
    logic        [FW:0]   r_quo;
    logic        [FW-1:0] r_coef [2];
    logic        [FW-1:0] r_msh;
    logic signed [CW+FW+1:0] r_acc;
    logic signed [CW:0]   r_dif;
    logic signed [CW-1:0] r_res [6];

    // Output register.
    logic                 r_oval;
    t_seg                 r_odata;

    // Edge test at the current level.
    logic [2:0] w_cr;
    logic [1:0] w_ep [3][2];
    always_comb begin
        w_ep[0][0] = 2'd0; w_ep[0][1] = 2'd1;
        w_ep[1][0] = 2'd0; w_ep[1][1] = 2'd2;
        w_ep[2][0] = 2'd1; w_ep[2][1] = 2'd2;
        for (int e = 0; e < 3; e++) begin
            logic signed [HW-1:0] zp, zq;
            zp = HW'(r_v[w_ep[e][0]][2]);
            zq = HW'(r_v[w_ep[e][1]][2]);
            w_cr[e] = (zp < r_h && zq > r_h) || (zp > r_h && zq < r_h);
        end
    end

    logic w_two;
    assign w_two = ($countones(w_cr) == 2);
    logic w_end;
    assign w_end = (r_h < HW'(r_bot)) || (r_k == KW'(MAX_LEVELS));

    logic [1:0] w_e0, w_e1;
    always_comb begin
        w_e0 = w_cr[0] ? 2'd0 : 2'd1;
        w_e1 = w_cr[2] ? 2'd2 : 2'd1;
    end

    // Divider operands for crossing r_sel[0]-selected edge; the multiplier
    // takes the edge from the upper half of r_sel.
    logic        w_ci;
    logic [1:0]  w_lo, w_hi;
    assign w_ci = (r_state == ST_DIV) ? r_sel[0] : (r_sel >= 3'd3);
    assign w_lo = r_lo[w_ci];
    assign w_hi = r_hi[w_ci];

    logic [1:0]  w_cc;
    always_comb begin
        case (r_sel)
            3'd0, 3'd3: w_cc = 2'd0;
            3'd1, 3'd4: w_cc = 2'd1;
            default:    w_cc = 2'd2;
        endcase
    end

    logic [CW+1:0] w_sub;
    assign w_sub = {r_rem, 1'b0} - {1'b0, r_den};

    logic signed [CW+FW+1:0] w_add;
    assign w_add = r_acc + (r_msh[0] ? ((CW+FW+2)'(r_dif) <<< 16) : '0);

    assign o_stall = (r_state != ST_IDLE);

    // Hand the finished result to the output register once it is free.
    logic w_load;
    assign w_load = (r_state == ST_OUT) && (!r_oval || !i_stall);

    t_seg w_seg;
    always_comb begin
        w_seg = '0;
        if (r_found) begin
            w_seg.found       = 1'b1;
            w_seg.level_index = r_k[IW-1:0];
            w_seg.start_x     = r_res[0];
            w_seg.start_y     = r_res[1];
            w_seg.start_z     = r_res[2];
            w_seg.end_x       = r_res[3];
            w_seg.end_y       = r_res[4];
            w_seg.end_z       = r_res[5];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_end) n_state = ST_OUT;
                else if (w_two) n_state = ST_DIV;
            end
            ST_DIV: if (r_cnt == 5'd16 && r_sel == 3'd1) n_state = ST_MUL;
            ST_MUL: if (r_cnt == 5'd16 && r_sel == 3'd5) n_state = ST_OUT;
            ST_OUT: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_top   <= 24'sd65536;
            r_bot   <= '0;
            r_step  <= 23'd6554;
            r_oval  <= 1'b0;
            r_odata <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_oval  <= 1'b1;
                r_odata <= w_seg;
            end else if (!i_stall) begin
                r_oval  <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOP:    r_top  <= i_cfg_data;
                    REG_BOTTOM: r_bot  <= i_cfg_data;
                    REG_STEP:   r_step <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_v[0][0] <= i_data.corner_a_x; r_v[0][1] <= i_data.corner_a_y;
                r_v[0][2] <= i_data.corner_a_z; r_v[1][0] <= i_data.corner_b_x;
                r_v[1][1] <= i_data.corner_b_y; r_v[1][2] <= i_data.corner_b_z;
                r_v[2][0] <= i_data.corner_c_x; r_v[2][1] <= i_data.corner_c_y;
                r_v[2][2] <= i_data.corner_c_z;
                r_h     <= HW'(r_top);
                r_k     <= '0;
                r_found <= 1'b0;
            end
            ST_SCAN: begin
                if (!w_end && w_two) begin
                    r_found <= 1'b1;
                    // Order each chosen edge as lower, higher endpoint.
                    if (r_v[w_ep[w_e0][0]][2] < r_v[w_ep[w_e0][1]][2]) begin
                        r_lo[0] <= w_ep[w_e0][0]; r_hi[0] <= w_ep[w_e0][1];
                    end else begin
                        r_lo[0] <= w_ep[w_e0][1]; r_hi[0] <= w_ep[w_e0][0];
                    end
                    if (r_v[w_ep[w_e1][0]][2] < r_v[w_ep[w_e1][1]][2]) begin
                        r_lo[1] <= w_ep[w_e1][0]; r_hi[1] <= w_ep[w_e1][1];
                    end else begin
                        r_lo[1] <= w_ep[w_e1][1]; r_hi[1] <= w_ep[w_e1][0];
                    end
                    r_sel <= 3'd0;
                    r_cnt <= 5'd0;
                end else if (!w_end) begin
                    r_h <= r_h - HW'(r_step);
                    r_k <= r_k + 1'b1;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit a cycle; step 0 loads.
                if (r_cnt == 5'd0) begin
                    r_rem <= (CW+1)'(r_h - HW'(r_v[w_lo][2]));
                    r_den <= (CW+1)'(HW'(r_v[w_hi][2]) - HW'(r_v[w_lo][2]));
                    r_quo <= '0;
                    r_cnt <= 5'd1;
                end else begin
                    if (!w_sub[CW+1]) begin
                        r_rem <= w_sub[CW:0];
                        r_quo <= {r_quo[FW-1:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[CW-1:0], 1'b0};
                        r_quo <= {r_quo[FW-1:0], 1'b0};
                    end
                    if (r_cnt == 5'd16) begin
                        r_coef[r_sel[0]] <= w_sub[CW+1] ? {r_quo[FW-2:0], 1'b0}
                                                        : {r_quo[FW-2:0], 1'b1};
                        r_cnt <= 5'd0;
                        r_sel <= (r_sel == 3'd0) ? 3'd1 : 3'd0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                if (r_cnt == 5'd16 && r_sel == 3'd1) r_sel <= 3'd0;
            end
            ST_MUL: begin
                // Shift-add multiply of coefficient by difference, LSB first.
                if (r_cnt == 5'd0) begin
                    r_msh <= r_coef[w_ci];
                    r_dif <= (CW+1)'(r_v[w_hi][w_cc]) - (CW+1)'(r_v[w_lo][w_cc]);
                    r_acc <= '0;
                    r_cnt <= 5'd1;
                end else begin
                    r_acc <= w_add >>> 1;
                    r_msh <= r_msh >> 1;
                    if (r_cnt == 5'd16) begin
                        r_res[r_sel] <= r_v[w_lo][w_cc] +
                            CW'(((w_add >>> 1) + (CW+FW+2)'(32768)) >>> 16);
                        r_cnt <= 5'd0;
                        r_sel <= r_sel + 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (r_state == ST_DIV && n_state == ST_MUL) begin
            r_sel <= 3'd0;
            r_cnt <= 5'd0;
        end
    end

    // Division entry: after the first coefficient, r_sel selects edge 1.
    // (r_sel[0] doubles as the edge index during division.)

    assign o_valid = r_oval;
    assign o_data  = r_odata;

endmodule
